FILE: rtl/wctm_pkg.sv
// Package for the wall column texture mapper: field widths, beat layouts,
// command, texture and register codes, controller states and helpers.
// No dependencies; every other rtl file imports it.
package wctm_pkg;

  // fixed point and screen geometry
  localparam int FRAC_BITS     = 16;
  localparam int SCREEN_HEIGHT = 1024;
  localparam int HALF_SCREEN   = SCREEN_HEIGHT / 2;

  // field widths
  localparam int COORD_W = 10;
  localparam int DIR_W   = 18;
  localparam int POS_W   = 24;
  localparam int DIST_W  = 24;
  localparam int LH_W    = 16;
  localparam int DIM_W   = 13;
  localparam int TEXEL_W = 12;
  localparam int TID_W   = 2;

  // texture size limits and reset value
  localparam int DIM_MAX   = 4096;
  localparam int DIM_RESET = 64;

  // derived datapath widths
  localparam int HIT_W      = 2 * FRAC_BITS;
  localparam int QUO_W      = DIM_W + FRAC_BITS;
  localparam int BASE_W     = LH_W + 1;
  localparam int TEX_POS_W  = 40;
  localparam int TY_RAW_W   = TEX_POS_W - FRAC_BITS;
  localparam int MUL_A_W    = HIT_W + 1;
  localparam int MUL_B_W    = QUO_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

  // configuration port
  localparam int CFG_IDX_W = 4;

  // input beat layout, lowest bit first
  localparam int IN_COL_LSB  = 0;
  localparam int IN_SIDE_LSB = IN_COL_LSB + COORD_W;
  localparam int IN_DX_LSB   = IN_SIDE_LSB + 1;
  localparam int IN_DY_LSB   = IN_DX_LSB + DIR_W;
  localparam int IN_PX_LSB   = IN_DY_LSB + DIR_W;
  localparam int IN_PY_LSB   = IN_PX_LSB + POS_W;
  localparam int IN_DIST_LSB = IN_PY_LSB + POS_W;
  localparam int IN_LH_LSB   = IN_DIST_LSB + DIST_W;
  localparam int IN_DS_LSB   = IN_LH_LSB + LH_W;
  localparam int IN_DE_LSB   = IN_DS_LSB + COORD_W;
  localparam int IN_USED_W   = IN_DE_LSB + COORD_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output beat layout, lowest bit first
  localparam int OUT_COL_LSB = 0;
  localparam int OUT_ROW_LSB = OUT_COL_LSB + COORD_W;
  localparam int OUT_TID_LSB = OUT_ROW_LSB + COORD_W;
  localparam int OUT_TX_LSB  = OUT_TID_LSB + TID_W;
  localparam int OUT_TY_LSB  = OUT_TX_LSB + TEXEL_W;
  localparam int OUT_USED_W  = OUT_TY_LSB + TEXEL_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // command carried in the input tuser
  typedef enum logic {
    CMD_COLUMN = 1'b0,
    CMD_ROW    = 1'b1
  } cmd_e;

  // wall textures
  typedef enum logic [TID_W-1:0] {
    TEX_WEST  = 2'd0,
    TEX_EAST  = 2'd1,
    TEX_NORTH = 2'd2,
    TEX_SOUTH = 2'd3
  } tex_id_e;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WEST_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WEST_HEIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_EAST_WIDTH   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_EAST_HEIGHT  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_NORTH_WIDTH  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_NORTH_HEIGHT = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_SOUTH_WIDTH  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SOUTH_HEIGHT = CFG_IDX_W'(7);

  // column set-up sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_HIT,
    ST_TEX_X,
    ST_MUL_X,
    ST_FLIP,
    ST_DIV_WAIT,
    ST_MUL_POS,
    ST_COMMIT
  } state_e;

  // texture size as used: zero becomes one, too large becomes the maximum
  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_MAX)) begin
      r = DIM_W'(DIM_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/wctm_div.sv
// Restoring divider for the vertical texture step, one quotient bit a cycle.
// Depends on wctm_pkg for the dividend, divisor and counter widths.
module wctm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wctm_pkg::QUO_W-1:0]  dividend_i,
  input  logic [wctm_pkg::LH_W-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [wctm_pkg::QUO_W-1:0]  quotient_o
);
  import wctm_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [LH_W-1:0]      rem_q, rem_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [LH_W-1:0]      dvs_q;
  logic [LH_W:0]        rem_sh;
  logic [LH_W+1:0]      diff;
  logic                 fits;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem_q, quo_q[QUO_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    fits   = ~diff[LH_W+1];
    rem_d  = fits ? diff[LH_W-1:0] : rem_sh[LH_W-1:0];
    quo_d  = {quo_q[QUO_W-2:0], fits};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(QUO_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/wall_column_texture_mapper.sv
// Wall column texture mapper: column set-up and per-row texel coordinates.
// Depends on wctm_pkg and the step divider wctm_div.
// Row beat: result registered next cycle, one per cycle unless stalled.
// Column beat: input ready low through set-up, paced by the 29-step divider;
//   the hit, column and position multiplies share one registered multiplier.
// Reset: sequencer idle, no column running, texture sizes 64, output empty.
module wall_column_texture_mapper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // column(10) side(1) dir_x(18) dir_y(18) pos_x(24) pos_y(24)
  // wall_dist(24) wall_h(16) row_top(10) row_bottom(10), zero pad
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [wctm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // cmd(1)
  input  logic                              s_axis_tuser,
  // out_column(10) out_row(10) texture_id(2) texel_x(12) texel_y(12), zero pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wctm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // in_range(1)
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [wctm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wctm_pkg::DIM_W-1:0]        cfg_data_i
);
  import wctm_pkg::*;

  // texture size registers
  logic [DIM_W-1:0] tex_w_q [4];
  logic [DIM_W-1:0] tex_h_q [4];

  // input beat fields
  logic [COORD_W-1:0]      in_col, in_ds, in_de;
  logic                    in_side;
  logic signed [DIR_W-1:0] in_dx, in_dy;
  logic [POS_W-1:0]        in_px, in_py;
  logic [DIST_W-1:0]       in_dist;
  logic [LH_W-1:0]         in_lh, lh_fix;
  tex_id_e                 in_tid;
  logic [DIM_W-1:0]        sel_w, sel_h;

  logic in_acc, col_acc, row_acc;

  // sequencer
  state_e state_q, state_d;
  logic   load_x, load_pos, flip_en, commit_en;

  // column state
  tex_id_e                  sel_tex_q;
  logic [DIM_W-1:0]         cur_w_q, cur_h_q;
  logic [COORD_W-1:0]       cur_col_q, cur_row_q, end_row_q;
  logic [FRAC_BITS-1:0]     pos_lo_q;
  logic signed [BASE_W-1:0] base_q;
  logic                     live_q, active_q;
  logic [TEXEL_W-1:0]       texel_x_q;
  logic [QUO_W-1:0]         step_q;
  logic signed [TEX_POS_W-1:0] tex_pos_q;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a_q, mul_a_d;
  logic signed [MUL_B_W-1:0] mul_b_q, mul_b_d;
  logic signed [PROD_W-1:0]  prod_q;
  logic [HIT_W-1:0]          frac;
  logic [TEXEL_W-1:0]        tx_raw, tx_flip;

  // divider
  logic             div_busy;
  logic [QUO_W-1:0] div_quo;

  // row result
  logic [TY_RAW_W-1:0] ty_raw;
  logic                row_neg, row_ok, row_fin;
  logic [TEXEL_W-1:0]  row_ty;

  // output register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_ok_q, out_last_q;

  // unpack the input beat
  always_comb begin
    in_col  = s_axis_tdata[IN_COL_LSB +: COORD_W];
    in_side = s_axis_tdata[IN_SIDE_LSB];
    in_dx   = $signed(s_axis_tdata[IN_DX_LSB +: DIR_W]);
    in_dy   = $signed(s_axis_tdata[IN_DY_LSB +: DIR_W]);
    in_px   = s_axis_tdata[IN_PX_LSB +: POS_W];
    in_py   = s_axis_tdata[IN_PY_LSB +: POS_W];
    in_dist = s_axis_tdata[IN_DIST_LSB +: DIST_W];
    in_lh   = s_axis_tdata[IN_LH_LSB +: LH_W];
    in_ds   = s_axis_tdata[IN_DS_LSB +: COORD_W];
    in_de   = s_axis_tdata[IN_DE_LSB +: COORD_W];
    lh_fix  = (in_lh == '0) ? LH_W'(1) : in_lh;
  end

  // texture choice from hit side and direction sign
  always_comb begin
    if (!in_side && in_dx > 0) begin
      in_tid = TEX_WEST;
    end else if (!in_side && in_dx < 0) begin
      in_tid = TEX_EAST;
    end else if (in_side && in_dy > 0) begin
      in_tid = TEX_NORTH;
    end else begin
      in_tid = TEX_SOUTH;
    end
    sel_w = dim_clamp(tex_w_q[in_tid]);
    sel_h = dim_clamp(tex_h_q[in_tid]);
  end

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign col_acc = in_acc && (s_axis_tuser == CMD_COLUMN);
  assign row_acc = in_acc && (s_axis_tuser == CMD_ROW) && active_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (col_acc) state_d = ST_MUL_HIT;
      ST_MUL_HIT:  state_d = ST_TEX_X;
      ST_TEX_X:    state_d = ST_MUL_X;
      ST_MUL_X:    state_d = ST_FLIP;
      ST_FLIP:     state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (!div_busy) state_d = ST_MUL_POS;
      ST_MUL_POS:  state_d = ST_COMMIT;
      ST_COMMIT:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_x        = 1'b0;
    load_pos      = 1'b0;
    flip_en       = 1'b0;
    commit_en     = 1'b0;
    case (state_q)
      ST_IDLE:     s_axis_tready = !m_valid_q || m_axis_tready;
      ST_TEX_X:    load_x        = 1'b1;
      ST_FLIP:     flip_en       = 1'b1;
      ST_DIV_WAIT: load_pos      = !div_busy;
      ST_COMMIT:   commit_en     = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // multiplier operands: hit offset, texture column, start position
  assign frac = prod_q[HIT_W-1:0] + {pos_lo_q, {FRAC_BITS{1'b0}}};

  always_comb begin
    mul_a_d = mul_a_q;
    mul_b_d = mul_b_q;
    if (col_acc) begin
      mul_a_d = MUL_A_W'(in_dist);
      mul_b_d = in_side ? MUL_B_W'(in_dx) : MUL_B_W'(in_dy);
    end else if (load_x) begin
      mul_a_d = MUL_A_W'(frac);
      mul_b_d = MUL_B_W'(cur_w_q);
    end else if (load_pos) begin
      mul_a_d = MUL_A_W'(base_q);
      mul_b_d = MUL_B_W'(div_quo);
    end
  end

  always_ff @(posedge clk_i) begin
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    prod_q  <= mul_a_q * mul_b_q;
  end

  // texture column, mirrored for east and north
  always_comb begin
    tx_raw  = prod_q[HIT_W +: TEXEL_W];
    tx_flip = TEXEL_W'(cur_w_q - DIM_W'(tx_raw) - DIM_W'(1));
  end

  wctm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (col_acc),
    .dividend_i ({sel_h, {FRAC_BITS{1'b0}}}),
    .divisor_i  (lh_fix),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // row texel from the running texture position
  always_comb begin
    ty_raw  = tex_pos_q[TEX_POS_W-1:FRAC_BITS];
    row_neg = tex_pos_q[TEX_POS_W-1];
    row_ok  = !row_neg || ((&ty_raw) && (|tex_pos_q[FRAC_BITS-1:0]));
    if (row_neg) begin
      row_ty = '0;
    end else if (ty_raw >= TY_RAW_W'(cur_h_q)) begin
      row_ty = TEXEL_W'(cur_h_q - DIM_W'(1));
    end else begin
      row_ty = ty_raw[TEXEL_W-1:0];
    end
    row_fin = cur_row_q >= end_row_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (col_acc) begin
        active_q <= 1'b0;
      end else if (commit_en) begin
        active_q <= live_q;
      end else if (row_acc && row_fin) begin
        active_q <= 1'b0;
      end
      if (row_acc) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // texture size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        tex_w_q[i] <= DIM_W'(DIM_RESET);
        tex_h_q[i] <= DIM_W'(DIM_RESET);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WEST_WIDTH:   tex_w_q[TEX_WEST]  <= cfg_data_i;
        REG_WEST_HEIGHT:  tex_h_q[TEX_WEST]  <= cfg_data_i;
        REG_EAST_WIDTH:   tex_w_q[TEX_EAST]  <= cfg_data_i;
        REG_EAST_HEIGHT:  tex_h_q[TEX_EAST]  <= cfg_data_i;
        REG_NORTH_WIDTH:  tex_w_q[TEX_NORTH] <= cfg_data_i;
        REG_NORTH_HEIGHT: tex_h_q[TEX_NORTH] <= cfg_data_i;
        REG_SOUTH_WIDTH:  tex_w_q[TEX_SOUTH] <= cfg_data_i;
        REG_SOUTH_HEIGHT: tex_h_q[TEX_SOUTH] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // column payload and row advance
  always_ff @(posedge clk_i) begin
    if (col_acc) begin
      sel_tex_q <= in_tid;
      cur_w_q   <= sel_w;
      cur_h_q   <= sel_h;
      cur_col_q <= in_col;
      cur_row_q <= in_ds;
      end_row_q <= in_de;
      pos_lo_q  <= in_side ? in_px[FRAC_BITS-1:0] : in_py[FRAC_BITS-1:0];
      base_q    <= $signed(BASE_W'(in_ds) + BASE_W'(lh_fix >> 1) - BASE_W'(HALF_SCREEN));
      live_q    <= in_ds <= in_de;
    end else if (row_acc) begin
      tex_pos_q <= tex_pos_q + $signed(TEX_POS_W'(step_q));
      if (!row_fin) begin
        cur_row_q <= cur_row_q + COORD_W'(1);
      end
    end
    if (flip_en) begin
      texel_x_q <= (sel_tex_q == TEX_EAST || sel_tex_q == TEX_NORTH) ? tx_flip : tx_raw;
    end
    if (load_pos) begin
      step_q <= div_quo;
    end
    if (commit_en) begin
      tex_pos_q <= prod_q[TEX_POS_W-1:0];
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (row_acc) begin
      out_data_q <= OUT_TDATA_W'({(row_ok ? row_ty : TEXEL_W'(0)), texel_x_q,
                                  sel_tex_q, cur_row_q, cur_col_q});
      out_ok_q   <= row_ok;
      out_last_q <= row_fin;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/wctm_chk.sv
// Port-level checks for the wall column texture mapper, bound to the top.
// Depends on wctm_pkg for the command codes and the output beat layout.
module wctm_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [wctm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tuser,
  input logic                              m_axis_tlast
);
  import wctm_pkg::*;

  // a column beat starts the set-up, which holds off the next beat
  a_col_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_COLUMN) |=> !s_axis_tready)
    else $error("input ready right after a column beat");

  // a result only follows an accepted row beat
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_ROW))
    else $error("result beat without a row beat");

  // out of range texels carry row zero
  a_black_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[OUT_TY_LSB +: TEXEL_W] == '0))
    else $error("texel_y nonzero on an out of range beat");

  // input is only taken when the output register can take the result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && m_axis_tvalid) |-> m_axis_tready)
    else $error("input ready while a result is stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("stalled result beat changed");

endmodule

bind wall_column_texture_mapper wctm_chk u_wctm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
